// ===== rtl/mde_pkg.sv =====
// Shared types and constants for the edit-script engine.
`default_nettype none
package mde_pkg;
    localparam int MaxLines   = 32;
    localparam int TokenBits  = 32;
    localparam int IdxW       = $clog2(MaxLines);
    localparam int CntW       = IdxW + 1;
    localparam int PosW       = CntW;
    localparam int DiagOff    = 2 * MaxLines;
    localparam int DiagSpan   = 4 * MaxLines + 1;
    localparam int DiagW      = $clog2(DiagSpan);
    localparam int MaxD       = 2 * MaxLines;
    localparam int DW         = $clog2(MaxD + 1);
    localparam int TraceDepth = (MaxD + 1) * DiagSpan;
    localparam int TraceAw    = $clog2(TraceDepth);
    localparam int EditDepth  = 2 * MaxLines;
    localparam int EditAw     = $clog2(EditDepth);
    localparam int EditCntW   = EditAw + 1;

    localparam logic [1:0] CMD_OLD    = 2'd0;
    localparam logic [1:0] CMD_NEW    = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    localparam logic [1:0] EDIT_EQUAL  = 2'd0;
    localparam logic [1:0] EDIT_INSERT = 2'd1;
    localparam logic [1:0] EDIT_DELETE = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] line_token;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  edit_kind;
        logic [4:0]  line_index;
        logic [31:0] token;
        logic        dropped_lines;
        logic        last_edit;
    } t_out_item;
endpackage
`default_nettype wire

// ===== rtl/mde_stream_if.sv =====
// Valid/ready channel carrying one payload type.
`default_nettype none
interface mde_in_if;
    import mde_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mde_out_if;
    import mde_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/mde_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module mde_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/myers_diff_edit_script.sv =====
// Myers edit-script engine: line stores, diagonal search, backtrack, emit.
// Append transactions are accepted while idle; the block stays ready between appends.
// Finish: clear the reach vector, then per distance copy it into a trace row and search
// each diagonal and its snake; backtrack walks the trace per distance and per equal line;
// each edit is then emitted and held while the output stalls.
// Reset (synchronous, active low) clears counts, flag and sequencer; stores are not cleared.
`default_nettype none
module myers_diff_edit_script (
    input wire logic i_clk,
    input wire logic i_rst_n,
    mde_in_if.sink   s_in,
    mde_out_if.source m_out
);
    import mde_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_CLR    = 5'd1;   // clear reach vector
    localparam logic [4:0] S_COPY   = 5'd2;   // save reach vector into trace row d
    localparam logic [4:0] S_KRD1   = 5'd3;   // read v[k-1]
    localparam logic [4:0] S_KRD2   = 5'd4;   // read v[k+1]
    localparam logic [4:0] S_KSEL   = 5'd5;   // pick start x
    localparam logic [4:0] S_SNRD   = 5'd6;   // read tokens at x,y
    localparam logic [4:0] S_SNCMP  = 5'd7;   // compare, advance
    localparam logic [4:0] S_KWR    = 5'd8;   // write v[k], check end
    localparam logic [4:0] S_BSTART = 5'd9;
    localparam logic [4:0] S_BRD1   = 5'd10;  // trace[td][tk-1]
    localparam logic [4:0] S_BRD2   = 5'd11;  // trace[td][tk+1]
    localparam logic [4:0] S_BRD3   = 5'd12;  // hold trace[td][tk+1] on the read port
    localparam logic [4:0] S_BPREV  = 5'd13;
    localparam logic [4:0] S_BSNAKE = 5'd14;
    localparam logic [4:0] S_BEDGE  = 5'd15;
    localparam logic [4:0] S_ERD    = 5'd16;  // read edit buffer
    localparam logic [4:0] S_ETOK   = 5'd17;  // read token store
    localparam logic [4:0] S_EOUT   = 5'd18;  // hold result until taken
    localparam logic [4:0] S_VRD    = 5'd19;  // copy: vector read wait

    logic [4:0] r_state, n_state;

    logic [CntW-1:0] r_old_cnt, r_new_cnt;
    logic            r_ovf;
    logic [CntW-1:0] r_n, r_m;
    logic            r_drop;

    // signed working values: x,y in [-1..2*MaxLines+1]
    localparam int SW = PosW + 3;
    logic signed [SW-1:0] r_d, r_k, r_x, r_y, r_a, r_b, r_px, r_py, r_cx, r_cy, r_tk;
    logic [DiagW-1:0]     r_i;
    logic [EditCntW-1:0]  r_cnt, r_e;

    // reach vector RAM
    logic             v_we;
    logic [DiagW-1:0] v_wa, v_ra;
    logic [PosW-1:0]  v_wd, v_rd;
    mde_ram #(.Width(PosW), .Depth(DiagSpan)) u_vec (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_wa), .i_wdata(v_wd),
        .i_raddr(v_ra), .o_rdata(v_rd));

    // trace RAM
    logic               t_we;
    logic [TraceAw-1:0] t_wa, t_ra;
    logic [PosW-1:0]    t_rd;
    mde_ram #(.Width(PosW), .Depth(TraceDepth)) u_trace (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_wa), .i_wdata(v_rd),
        .i_raddr(t_ra), .o_rdata(t_rd));

    // line stores
    logic            o_we, nw_we;
    logic [IdxW-1:0] o_ra, nw_ra;
    logic [31:0]     o_rd, nw_rd;
    mde_ram #(.Width(32), .Depth(MaxLines)) u_old (
        .i_clk(i_clk), .i_we(o_we), .i_waddr(r_old_cnt[IdxW-1:0]),
        .i_wdata(s_in.data.line_token), .i_raddr(o_ra), .o_rdata(o_rd));
    mde_ram #(.Width(32), .Depth(MaxLines)) u_new (
        .i_clk(i_clk), .i_we(nw_we), .i_waddr(r_new_cnt[IdxW-1:0]),
        .i_wdata(s_in.data.line_token), .i_raddr(nw_ra), .o_rdata(nw_rd));

    // edit buffer: kind and index
    logic               e_we;
    logic [EditAw-1:0]  e_ra;
    logic [1+IdxW+1:0]  e_wd, e_rd;
    mde_ram #(.Width(IdxW + 3), .Depth(EditDepth)) u_edit (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(r_cnt[EditAw-1:0]), .i_wdata(e_wd),
        .i_raddr(e_ra), .o_rdata(e_rd));

    logic accept;
    assign accept = s_in.valid && s_in.ready;
    assign s_in.ready = (r_state == S_IDLE);

    // diagonal address of signed k + offset
    function automatic logic [DiagW-1:0] diag(input logic signed [SW-1:0] kk);
        logic signed [SW:0] s;
        s = (SW+1)'(kk) + (SW+1)'(DiagOff);
        return s[DiagW-1:0];
    endfunction

    logic [TraceAw-1:0] row_base;
    assign row_base = TraceAw'(r_d[DW-1:0]) * TraceAw'(DiagSpan);

    logic [1:0]      r_okind;
    logic [IdxW-1:0] r_oidx;
    logic            r_olast;

    logic bounds_ok;
    assign bounds_ok = !r_x[SW-1] && !r_y[SW-1] && (r_x < SW'(r_n)) && (r_y < SW'(r_m));

    always_comb begin
        n_state = r_state;
        v_we = 1'b0; v_wa = '0; v_wd = '0; v_ra = '0;
        t_we = 1'b0; t_wa = '0; t_ra = '0;
        o_we = 1'b0; nw_we = 1'b0;
        o_ra = r_x[IdxW-1:0]; nw_ra = r_y[IdxW-1:0];
        e_we = 1'b0; e_wd = '0;
        e_ra = EditAw'(r_cnt - EditCntW'(1) - r_e);
        if (accept && s_in.data.command == CMD_OLD && r_old_cnt < CntW'(MaxLines))
            o_we = 1'b1;
        if (accept && s_in.data.command == CMD_NEW && r_new_cnt < CntW'(MaxLines))
            nw_we = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (accept && s_in.data.command == CMD_FINISH && (r_old_cnt != '0 || r_new_cnt != '0))
                    n_state = S_CLR;
            end
            S_CLR: begin
                v_we = 1'b1; v_wa = r_i;
                if (r_i == DiagW'(DiagSpan - 1)) n_state = S_VRD;
            end
            S_VRD: begin
                v_ra = r_i;
                n_state = S_COPY;
            end
            S_COPY: begin
                // v_rd holds entry r_i-1 (pipelined read)
                v_ra = r_i;
                t_we = (r_i != '0);
                t_wa = row_base + TraceAw'(r_i) - TraceAw'(1);
                if (r_i == DiagW'(DiagSpan)) n_state = S_KRD1;
            end
            S_KRD1: begin v_ra = diag(r_k - SW'(1)); n_state = S_KRD2; end
            S_KRD2: begin v_ra = diag(r_k + SW'(1)); n_state = S_KSEL; end
            S_KSEL: n_state = S_SNRD;
            S_SNRD: n_state = bounds_ok ? S_SNCMP : S_KWR;
            S_SNCMP: n_state = (o_rd == nw_rd) ? S_SNRD : S_KWR;
            S_KWR: begin
                v_we = 1'b1; v_wa = diag(r_k); v_wd = r_x[PosW-1:0];
                if (r_x >= SW'(r_n) && r_y >= SW'(r_m)) n_state = S_BSTART;
                else if (r_k == r_d) n_state = S_VRD;
                else n_state = S_KRD1;
            end
            S_BSTART: n_state = (r_d == '0) ? S_BPREV : S_BRD1;
            S_BRD1: begin
                t_ra = row_base + TraceAw'(diag(r_tk - SW'(1)));
                n_state = S_BRD2;
            end
            S_BRD2: begin
                t_ra = row_base + TraceAw'(diag(r_tk + SW'(1)));
                n_state = S_BRD3;
            end
            S_BRD3: begin
                // keep trace[tk+1] on the read port for the decision
                t_ra = row_base + TraceAw'(diag(r_tk + SW'(1)));
                n_state = S_BPREV;
            end
            S_BPREV: n_state = S_BSNAKE;
            S_BSNAKE: begin
                if (r_cx > r_px && r_cy > r_py && r_cnt < EditCntW'(EditDepth)) begin
                    e_we = 1'b1;
                    e_wd = {EDIT_EQUAL, 1'b0, r_cx[IdxW-1:0] - IdxW'(1)};
                end else begin
                    n_state = S_BEDGE;
                end
            end
            S_BEDGE: begin
                if (r_d != '0 && r_cnt < EditCntW'(EditDepth)) begin
                    e_we = 1'b1;
                    if (r_cx == r_px)
                        e_wd = {EDIT_INSERT, 1'b0, r_cy[IdxW-1:0] - IdxW'(1)};
                    else
                        e_wd = {EDIT_DELETE, 1'b0, r_cx[IdxW-1:0] - IdxW'(1)};
                end
                n_state = (r_d == '0) ? S_ERD : S_BSTART;
            end
            S_ERD: n_state = S_ETOK;
            S_ETOK: begin
                o_ra = e_rd[IdxW-1:0]; nw_ra = e_rd[IdxW-1:0];
                n_state = S_EOUT;
            end
            S_EOUT: begin
                // keep re-reading the same line so the token holds while stalled
                o_ra = r_oidx; nw_ra = r_oidx;
                if (m_out.ready) n_state = r_olast ? S_IDLE : S_ERD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_old_cnt <= '0; r_new_cnt <= '0; r_ovf <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                case (s_in.data.command)
                    CMD_OLD: if (r_old_cnt < CntW'(MaxLines)) r_old_cnt <= r_old_cnt + CntW'(1);
                             else r_ovf <= 1'b1;
                    CMD_NEW: if (r_new_cnt < CntW'(MaxLines)) r_new_cnt <= r_new_cnt + CntW'(1);
                             else r_ovf <= 1'b1;
                    CMD_FINISH: begin
                        r_old_cnt <= '0; r_new_cnt <= '0; r_ovf <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // datapath: one shared compare/step unit steered by state
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_n <= r_old_cnt; r_m <= r_new_cnt; r_drop <= r_ovf;
                r_i <= '0; r_d <= '0; r_k <= '0; r_cnt <= '0; r_e <= '0;
            end
            S_CLR: r_i <= (r_i == DiagW'(DiagSpan - 1)) ? '0 : r_i + DiagW'(1);
            S_VRD: r_i <= r_i + DiagW'(1);
            S_COPY: begin
                if (r_i == DiagW'(DiagSpan)) begin
                    r_i <= '0; r_k <= -r_d;
                end else r_i <= r_i + DiagW'(1);
            end
            S_KRD2: r_a <= SW'(v_rd);           // v[k-1]
            S_KSEL: begin
                if (r_k == -r_d || (r_k != r_d && r_a < SW'(v_rd))) r_x <= SW'(v_rd);
                else r_x <= r_a + SW'(1);
                if (r_k == -r_d || (r_k != r_d && r_a < SW'(v_rd))) r_y <= SW'(v_rd) - r_k;
                else r_y <= r_a + SW'(1) - r_k;
            end
            S_SNCMP: if (o_rd == nw_rd) begin r_x <= r_x + SW'(1); r_y <= r_y + SW'(1); end
            S_KWR: begin
                if (r_x >= SW'(r_n) && r_y >= SW'(r_m)) begin
                    r_cx <= SW'(r_n); r_cy <= SW'(r_m); r_tk <= SW'(r_n) - SW'(r_m);
                end else if (r_k == r_d) begin
                    r_d <= r_d + SW'(1); r_i <= '0;
                end else r_k <= r_k + SW'(2);
            end
            S_BSTART: r_tk <= r_cx - r_cy;
            S_BRD2: r_a <= SW'(t_rd);            // trace[tk-1]
            S_BRD3: ;
            S_BPREV: begin
                if (r_d == '0) begin
                    r_px <= '0; r_py <= '0;
                end else begin
                    // t_rd = trace[tk+1]
                    if (r_tk == -r_d || (r_tk != r_d && r_a < SW'(t_rd))) begin
                        r_px <= SW'(t_rd); r_py <= SW'(t_rd) - (r_tk + SW'(1));
                    end else begin
                        r_px <= r_a; r_py <= r_a - (r_tk - SW'(1));
                    end
                end
            end
            S_BSNAKE: if (r_cx > r_px && r_cy > r_py && r_cnt < EditCntW'(EditDepth)) begin
                r_cx <= r_cx - SW'(1); r_cy <= r_cy - SW'(1); r_cnt <= r_cnt + EditCntW'(1);
            end
            S_BEDGE: begin
                if (r_d != '0 && r_cnt < EditCntW'(EditDepth)) begin
                    r_cnt <= r_cnt + EditCntW'(1);
                    if (r_cx == r_px) r_cy <= r_cy - SW'(1);
                    else r_cx <= r_cx - SW'(1);
                end
                if (r_d != '0) r_d <= r_d - SW'(1);
            end
            S_ETOK: begin
                r_okind <= e_rd[IdxW+2:IdxW+1];
                r_oidx  <= e_rd[IdxW-1:0];
                r_olast <= (r_e == r_cnt - EditCntW'(1));
            end
            S_EOUT: if (m_out.ready) r_e <= r_e + EditCntW'(1);
            default: ;
        endcase
    end

    assign m_out.valid = (r_state == S_EOUT);
    assign m_out.data.edit_kind = r_okind;
    assign m_out.data.line_index = 5'(r_oidx);
    assign m_out.data.token = (r_okind == EDIT_INSERT) ? nw_rd : o_rd;
    assign m_out.data.dropped_lines = r_drop;
    assign m_out.data.last_edit = r_olast;

    // the block never takes input while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid |-> !s_in.ready) else $error("input ready during emit");
    // emission index stays inside the collected script
    a_emit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid |-> r_e < r_cnt) else $error("emit past script end");
    // counts never exceed list capacity
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_old_cnt <= CntW'(MaxLines) && r_new_cnt <= CntW'(MaxLines))
        else $error("line count overflow");
endmodule
`default_nettype wire
